// ===== hw/rtl/aalr_pkg.sv =====
// Constants, widths and helper functions of the antialiased line rasterizer.
// Holds the gamma table and the screen clipping rule; depends on nothing.
package aalr_pkg;

    localparam int SCREEN_SPAN         = 1024;
    localparam int SLOPE_FRACTION_BITS = 16;

    // Input endpoints: unsigned fixed point with COORD_FRAC fraction bits
    localparam int COORD_W    = 14;
    localparam int COORD_FRAC = 4;
    localparam int PIX_W      = COORD_W + 1 - COORD_FRAC;
    localparam int COV_W      = 8;
    localparam int COLOR_W    = 24;

    localparam int SLOPE_W     = SLOPE_FRACTION_BITS + 2;
    localparam int QUOT_W      = SLOPE_FRACTION_BITS + 1;
    localparam int STEP_W      = $clog2(QUOT_W);
    localparam int MINOR_INT_W = COORD_W - COORD_FRAC + 2;
    localparam int Y_W         = SLOPE_FRACTION_BITS + MINOR_INT_W;
    localparam int ROW_W       = MINOR_INT_W + 1;
    localparam int GAP_W       = COORD_FRAC + 1;
    localparam int OPAC_W      = 9;
    localparam int WPROD_W     = SLOPE_FRACTION_BITS + 1 + GAP_W;

    localparam logic [OPAC_W-1:0] OPAC_FULL = OPAC_W'(256);
    localparam logic signed [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(1 << SLOPE_FRACTION_BITS);

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // round(255 * (i/32)^(1/2.2)) for i = 0..32
    localparam logic [7:0] GAMMA_PTS [0:32] = '{
        8'd0,   8'd53,  8'd72,  8'd87,  8'd99,  8'd110, 8'd119, 8'd128,
        8'd136, 8'd143, 8'd150, 8'd157, 8'd163, 8'd169, 8'd175, 8'd181,
        8'd186, 8'd191, 8'd196, 8'd201, 8'd206, 8'd211, 8'd215, 8'd219,
        8'd224, 8'd228, 8'd232, 8'd236, 8'd240, 8'd244, 8'd248, 8'd251,
        8'd255
    };

    // Piecewise-linear gamma curve over a Q8 opacity (0..256)
    function automatic logic [COV_W-1:0] gamma_lookup(input logic [OPAC_W-1:0] opac);
        logic [4:0]  idx;
        logic [2:0]  t;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [10:0] acc;
        idx = opac[7:3];
        t   = opac[2:0];
        lo  = GAMMA_PTS[idx];
        hi  = GAMMA_PTS[{1'b0, idx} + 6'd1];
        acc = 11'(hi - lo) * 11'(t) + 11'd4;
        if (opac[8]) begin
            return 8'hFF;
        end
        return COV_W'(lo + 8'(acc >> 3));
    endfunction

    // Off-screen coordinates report as the span, which fits in the port width
    function automatic logic [PIX_W-1:0] screen_coord(input logic signed [ROW_W-1:0] v);
        if (v[ROW_W-1] || int'(v) >= SCREEN_SPAN) begin
            return PIX_W'(SCREEN_SPAN);
        end
        return PIX_W'(v);
    endfunction

endpackage

// ===== hw/rtl/antialiased_line_rasterizer.sv =====
// Antialiased line rasterizer (Wu style): line setup, gradient divider and pixel emitter.
// Uses aalr_pkg for widths, the gamma table and screen clipping.
//
// Load item: orient, order, delta, the 17-step shared divider and sign, then four results;
//   the divider is skipped when both endpoints share a major coordinate.
// Advance item: two results. Each item is run to its end before the next is taken.
// Results sit in an output register, so the next item is taken while the last one waits.
// aresetn (synchronous, active low) clears the sequencer, the line-active flag and m_valid.
module antialiased_line_rasterizer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [aalr_pkg::COORD_W-1:0] s_start_x,
    input  logic [aalr_pkg::COORD_W-1:0] s_start_y,
    input  logic [aalr_pkg::COORD_W-1:0] s_end_x,
    input  logic [aalr_pkg::COORD_W-1:0] s_end_y,
    input  logic [aalr_pkg::COLOR_W-1:0] s_line_color,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [aalr_pkg::PIX_W-1:0]   m_pixel_x,
    output logic [aalr_pkg::PIX_W-1:0]   m_pixel_y,
    output logic [aalr_pkg::COV_W-1:0]   m_coverage,
    output logic [aalr_pkg::COLOR_W-1:0] m_pixel_color,
    output logic                         m_last,
    output logic                         m_line_done
);

    localparam int F  = aalr_pkg::SLOPE_FRACTION_BITS;
    localparam int CW = aalr_pkg::COORD_W;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_ORIENT = 9'b0_0000_0010,
        ST_ORDER  = 9'b0_0000_0100,
        ST_DELTA  = 9'b0_0000_1000,
        ST_DIVIDE = 9'b0_0001_0000,
        ST_SIGN   = 9'b0_0010_0000,
        ST_EP_Y   = 9'b0_0100_0000,
        ST_OPAC   = 9'b0_1000_0000,
        ST_EMIT   = 9'b1_0000_0000
    } state_t;

    // Control registers
    state_t state_reg, state_next;
    logic   active_reg, active_next;
    logic   ep_mode_reg, ep_mode_next;
    logic   ep_sel_reg, ep_sel_next;
    logic   row_hi_reg, row_hi_next;
    logic   m_valid_reg, m_valid_next;
    logic [aalr_pkg::STEP_W-1:0] div_cnt_reg, div_cnt_next;

    // Line and work registers
    logic [CW-1:0] p_x0_reg, p_x0_next;
    logic [CW-1:0] p_y0_reg, p_y0_next;
    logic [CW-1:0] p_x1_reg, p_x1_next;
    logic [CW-1:0] p_y1_reg, p_y1_next;
    logic          steep_reg, steep_next;
    logic [CW-1:0] dx_reg, dx_next;
    logic          dy_neg_reg, dy_neg_next;
    logic [CW-1:0] div_rem_reg, div_rem_next;
    logic [aalr_pkg::QUOT_W-1:0] div_q_reg, div_q_next;
    logic signed [aalr_pkg::SLOPE_W-1:0] slope_reg, slope_next;
    logic signed [aalr_pkg::Y_W-1:0]     intercept_reg, intercept_next;
    logic [aalr_pkg::PIX_W-1:0]          column_reg, column_next;
    logic [aalr_pkg::PIX_W-1:0]          last_column_reg, last_column_next;
    logic [aalr_pkg::COLOR_W-1:0]        held_color_reg, held_color_next;
    logic signed [aalr_pkg::Y_W-1:0]     work_y_reg, work_y_next;
    logic [aalr_pkg::PIX_W-1:0]          work_major_reg, work_major_next;
    logic [aalr_pkg::GAP_W-1:0]          work_gap_reg, work_gap_next;
    logic [aalr_pkg::OPAC_W-1:0]         opac_reg, opac_next;
    logic signed [aalr_pkg::ROW_W-1:0]   row_reg, row_next;

    // Output register
    logic [aalr_pkg::PIX_W-1:0]   m_pixel_x_reg, m_pixel_x_next;
    logic [aalr_pkg::PIX_W-1:0]   m_pixel_y_reg, m_pixel_y_next;
    logic [aalr_pkg::COV_W-1:0]   m_coverage_reg, m_coverage_next;
    logic [aalr_pkg::COLOR_W-1:0] m_pixel_color_reg, m_pixel_color_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_line_done_reg, m_line_done_next;

    // Setup datapath
    logic [CW-1:0] adx, ady, dy_mag;
    logic          steep_w;
    logic [CW:0]   xe_sum0, xe_sum1;
    logic [aalr_pkg::PIX_W:0] first_next_col;

    // Shared divider step
    logic [CW:0] div_trial, div_diff;
    logic        div_ge;

    // Endpoint datapath
    logic [CW-1:0] ep_x, ep_yq;
    logic [CW:0]   ep_sum;
    logic [aalr_pkg::COORD_FRAC-1:0] ep_frac;
    logic signed [aalr_pkg::GAP_W-1:0] ep_d;
    logic [aalr_pkg::GAP_W-1:0] ep_gap;
    logic signed [aalr_pkg::SLOPE_W+aalr_pkg::GAP_W-1:0] ep_prod;
    logic [aalr_pkg::Y_W-1:0] ep_base;
    logic signed [aalr_pkg::Y_W-1:0] ep_y;
    logic signed [aalr_pkg::Y_W-1:0] slope_ext;

    // Pixel datapath
    logic [F-1:0] fp_w;
    logic [F:0]   rf_w, weight_w;
    logic [aalr_pkg::WPROD_W-1:0] wprod_w;
    logic [aalr_pkg::OPAC_W-1:0]  opac_w;
    logic signed [aalr_pkg::ROW_W-1:0] row_w;
    logic [aalr_pkg::PIX_W-1:0] major_c, minor_c;
    logic line_done_w;
    logic out_free;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_pixel_x_reg;
    assign m_pixel_y     = m_pixel_y_reg;
    assign m_coverage    = m_coverage_reg;
    assign m_pixel_color = m_pixel_color_reg;
    assign m_last        = m_last_reg;
    assign m_line_done   = m_line_done_reg;

    assign adx     = (p_x1_reg >= p_x0_reg) ? p_x1_reg - p_x0_reg : p_x0_reg - p_x1_reg;
    assign ady     = (p_y1_reg >= p_y0_reg) ? p_y1_reg - p_y0_reg : p_y0_reg - p_y1_reg;
    assign steep_w = ady > adx;
    assign dy_mag  = (p_y1_reg < p_y0_reg) ? p_y0_reg - p_y1_reg : p_y1_reg - p_y0_reg;

    assign xe_sum0        = {1'b0, p_x0_reg} + (CW+1)'(8);
    assign xe_sum1        = {1'b0, p_x1_reg} + (CW+1)'(8);
    assign first_next_col = {1'b0, xe_sum0[CW:aalr_pkg::COORD_FRAC]} + (aalr_pkg::PIX_W+1)'(1);

    assign div_trial = {div_rem_reg, div_q_reg[aalr_pkg::QUOT_W-1]};
    assign div_ge    = div_trial >= {1'b0, dx_reg};
    assign div_diff  = div_trial - {1'b0, dx_reg};

    assign ep_x    = ep_sel_reg ? p_x1_reg : p_x0_reg;
    assign ep_yq   = ep_sel_reg ? p_y1_reg : p_y0_reg;
    assign ep_sum  = {1'b0, ep_x} + (CW+1)'(8);
    assign ep_frac = ep_sum[aalr_pkg::COORD_FRAC-1:0];
    // Offset from the endpoint to its column center: 8 - frac, in -7..8
    assign ep_d    = $signed(aalr_pkg::GAP_W'(8) - {1'b0, ep_frac});
    assign ep_gap  = ep_sel_reg ? {1'b0, ep_frac}
                                : aalr_pkg::GAP_W'(16) - {1'b0, ep_frac};
    assign ep_prod = slope_reg * ep_d;
    assign ep_base = {{(aalr_pkg::Y_W-CW-F+aalr_pkg::COORD_FRAC){1'b0}}, ep_yq,
                      {(F-aalr_pkg::COORD_FRAC){1'b0}}};
    assign ep_y    = $signed(ep_base)
                   + $signed(aalr_pkg::Y_W'(ep_prod >>> aalr_pkg::COORD_FRAC));
    assign slope_ext = aalr_pkg::Y_W'(slope_reg);

    assign fp_w     = work_y_reg[F-1:0];
    assign rf_w     = (F+1)'(1 << F) - {1'b0, fp_w};
    assign weight_w = row_hi_reg ? {1'b0, fp_w} : rf_w;
    assign wprod_w  = aalr_pkg::WPROD_W'(weight_w) * aalr_pkg::WPROD_W'(work_gap_reg);
    assign opac_w   = ep_mode_reg ? aalr_pkg::OPAC_W'(wprod_w >> (F - aalr_pkg::COORD_FRAC))
                                  : aalr_pkg::OPAC_W'(weight_w >> (F - 8));
    assign row_w    = $signed(aalr_pkg::ROW_W'(work_y_reg >>> F))
                    + $signed({{(aalr_pkg::ROW_W-1){1'b0}}, row_hi_reg});

    assign major_c = aalr_pkg::screen_coord(
        $signed({{(aalr_pkg::ROW_W-aalr_pkg::PIX_W){1'b0}}, work_major_reg}));
    assign minor_c = aalr_pkg::screen_coord(row_reg);

    assign line_done_w = ep_mode_reg
                       ? ({1'b0, column_reg} >= {1'b0, last_column_reg})
                       : ({1'b0, column_reg} + (aalr_pkg::PIX_W+1)'(1)
                          >= {1'b0, last_column_reg});
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next         = state_reg;
        active_next        = active_reg;
        ep_mode_next       = ep_mode_reg;
        ep_sel_next        = ep_sel_reg;
        row_hi_next        = row_hi_reg;
        div_cnt_next       = div_cnt_reg;
        p_x0_next          = p_x0_reg;
        p_y0_next          = p_y0_reg;
        p_x1_next          = p_x1_reg;
        p_y1_next          = p_y1_reg;
        steep_next         = steep_reg;
        dx_next            = dx_reg;
        dy_neg_next        = dy_neg_reg;
        div_rem_next       = div_rem_reg;
        div_q_next         = div_q_reg;
        slope_next         = slope_reg;
        intercept_next     = intercept_reg;
        column_next        = column_reg;
        last_column_next   = last_column_reg;
        held_color_next    = held_color_reg;
        work_y_next        = work_y_reg;
        work_major_next    = work_major_reg;
        work_gap_next      = work_gap_reg;
        opac_next          = opac_reg;
        row_next           = row_reg;
        m_pixel_x_next     = m_pixel_x_reg;
        m_pixel_y_next     = m_pixel_y_reg;
        m_coverage_next    = m_coverage_reg;
        m_pixel_color_next = m_pixel_color_reg;
        m_last_next        = m_last_reg;
        m_line_done_next   = m_line_done_reg;
        m_valid_next       = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == aalr_pkg::KIND_LOAD) begin
                        p_x0_next       = s_start_x;
                        p_y0_next       = s_start_y;
                        p_x1_next       = s_end_x;
                        p_y1_next       = s_end_y;
                        held_color_next = s_line_color;
                        ep_mode_next    = 1'b1;
                        ep_sel_next     = 1'b0;
                        state_next      = ST_ORIENT;
                    end else if (active_reg) begin
                        work_y_next     = intercept_reg;
                        work_major_next = column_reg;
                        ep_mode_next    = 1'b0;
                        row_hi_next     = 1'b0;
                        state_next      = ST_OPAC;
                    end
                end
            end
            ST_ORIENT: begin
                // Steep lines run along y: swap the axes
                steep_next = steep_w;
                if (steep_w) begin
                    p_x0_next = p_y0_reg;
                    p_y0_next = p_x0_reg;
                    p_x1_next = p_y1_reg;
                    p_y1_next = p_x1_reg;
                end
                state_next = ST_ORDER;
            end
            ST_ORDER: begin
                if (p_x0_reg > p_x1_reg) begin
                    p_x0_next = p_x1_reg;
                    p_y0_next = p_y1_reg;
                    p_x1_next = p_x0_reg;
                    p_y1_next = p_y0_reg;
                end
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                dx_next      = p_x1_reg - p_x0_reg;
                dy_neg_next  = p_y1_reg < p_y0_reg;
                // |dy| <= dx, so the top bits of |dy| << F already sit below the divisor
                div_rem_next = {1'b0, dy_mag[CW-1:1]};
                div_cnt_next = '0;
                if (p_x1_reg == p_x0_reg) begin
                    div_q_next = '0;
                    state_next = ST_SIGN;
                end else begin
                    div_q_next = {dy_mag[0], {F{1'b0}}};
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                div_rem_next = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
                div_q_next   = {div_q_reg[aalr_pkg::QUOT_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + aalr_pkg::STEP_W'(1);
                if (div_cnt_reg == aalr_pkg::STEP_W'(aalr_pkg::QUOT_W - 1)) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                slope_next       = dy_neg_reg ? -$signed({1'b0, div_q_reg})
                                              : $signed({1'b0, div_q_reg});
                column_next      = first_next_col[aalr_pkg::PIX_W-1:0];
                last_column_next = xe_sum1[CW:aalr_pkg::COORD_FRAC];
                active_next      = first_next_col < {1'b0, xe_sum1[CW:aalr_pkg::COORD_FRAC]};
                ep_sel_next      = 1'b0;
                state_next       = ST_EP_Y;
            end
            ST_EP_Y: begin
                work_y_next     = ep_y;
                work_major_next = ep_sum[CW:aalr_pkg::COORD_FRAC];
                work_gap_next   = ep_gap;
                row_hi_next     = 1'b0;
                state_next      = ST_OPAC;
            end
            ST_OPAC: begin
                opac_next = opac_w;
                row_next  = row_w;
                if (ep_mode_reg && !ep_sel_reg && !row_hi_reg) begin
                    intercept_next = work_y_reg + slope_ext;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_pixel_x_next     = steep_reg ? minor_c : major_c;
                    m_pixel_y_next     = steep_reg ? major_c : minor_c;
                    m_coverage_next    = aalr_pkg::gamma_lookup(opac_reg);
                    m_pixel_color_next = held_color_reg;
                    m_last_next        = row_hi_reg && (!ep_mode_reg || ep_sel_reg);
                    m_line_done_next   = line_done_w;
                    if (!row_hi_reg) begin
                        row_hi_next = 1'b1;
                        state_next  = ST_OPAC;
                    end else if (ep_mode_reg && !ep_sel_reg) begin
                        ep_sel_next = 1'b1;
                        state_next  = ST_EP_Y;
                    end else begin
                        // Advance to the next column after its pair is out
                        if (!ep_mode_reg) begin
                            column_next    = column_reg + aalr_pkg::PIX_W'(1);
                            intercept_next = intercept_reg + slope_ext;
                            if (line_done_w) begin
                                active_next = 1'b0;
                            end
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            ep_mode_reg <= 1'b0;
            ep_sel_reg  <= 1'b0;
            row_hi_reg  <= 1'b0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            ep_mode_reg <= ep_mode_next;
            ep_sel_reg  <= ep_sel_next;
            row_hi_reg  <= row_hi_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_x0_reg          <= p_x0_next;
        p_y0_reg          <= p_y0_next;
        p_x1_reg          <= p_x1_next;
        p_y1_reg          <= p_y1_next;
        steep_reg         <= steep_next;
        dx_reg            <= dx_next;
        dy_neg_reg        <= dy_neg_next;
        div_rem_reg       <= div_rem_next;
        div_q_reg         <= div_q_next;
        slope_reg         <= slope_next;
        intercept_reg     <= intercept_next;
        column_reg        <= column_next;
        last_column_reg   <= last_column_next;
        held_color_reg    <= held_color_next;
        work_y_reg        <= work_y_next;
        work_major_reg    <= work_major_next;
        work_gap_reg      <= work_gap_next;
        opac_reg          <= opac_next;
        row_reg           <= row_next;
        m_pixel_x_reg     <= m_pixel_x_next;
        m_pixel_y_reg     <= m_pixel_y_next;
        m_coverage_reg    <= m_coverage_next;
        m_pixel_color_reg <= m_pixel_color_next;
        m_last_reg        <= m_last_next;
        m_line_done_reg   <= m_line_done_next;
    end

    a_div_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> (div_rem_reg < dx_reg))
        else $error("divider remainder reached the divisor");

    a_active_has_columns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && active_reg) |-> (column_reg < last_column_reg))
        else $error("active line with no interior column left");

    a_slope_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EP_Y) |->
            (slope_reg <= aalr_pkg::SLOPE_ONE) && (slope_reg >= -aalr_pkg::SLOPE_ONE))
        else $error("gradient magnitude above one");

    a_opacity_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (opac_reg <= aalr_pkg::OPAC_FULL))
        else $error("opacity above full coverage");

endmodule

// ===== tb/antialiased_line_rasterizer_tb.sv =====
// Self-checking testbench for the antialiased line rasterizer: drives load and advance
// transfers, predicts every pixel with its own Wu line model and checks each result in order.
// Depends on aalr_pkg (port widths, kind codes) and the antialiased_line_rasterizer RTL.
module antialiased_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPAN       = 1024;
    localparam int GRAD_FRAC  = 16;
    localparam int COORD_MAX  = (1 << aalr_pkg::COORD_W) - 1;
    localparam int LIMIT      = 400000;

    // round(255 * (i/32)^(1/2.2))
    localparam int GAMMA_CURVE [0:32] = '{
        0, 53, 72, 87, 99, 110, 119, 128, 136, 143, 150, 157, 163, 169, 175, 181,
        186, 191, 196, 201, 206, 211, 215, 219, 224, 228, 232, 236, 240, 244, 248,
        251, 255
    };

    typedef struct packed {
        logic [aalr_pkg::PIX_W-1:0]   x;
        logic [aalr_pkg::PIX_W-1:0]   y;
        logic [aalr_pkg::COV_W-1:0]   coverage;
        logic [aalr_pkg::COLOR_W-1:0] color;
        logic                         last;
        logic                         done;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t           expected_pixels[$];
        bit               line_active;
        bit               steep;
        longint           next_col;
        longint           end_col;
        longint           minor_acc;
        longint           gradient;
        logic [aalr_pkg::COLOR_W-1:0] color;
        int               failures;

        function automatic logic [aalr_pkg::COV_W-1:0] gamma_cov(longint opac);
            longint i, t, lo, hi;
            if (opac > 256) begin
                opac = 256;
            end
            i = opac >> 3;
            if (i >= 32) begin
                return 8'hFF;
            end
            t  = opac & 7;
            lo = GAMMA_CURVE[i];
            hi = GAMMA_CURVE[i + 1];
            return aalr_pkg::COV_W'(lo + ((hi - lo) * t + 4) / 8);
        endfunction

        function automatic logic [aalr_pkg::PIX_W-1:0] on_screen(longint v);
            if (v < 0 || v >= SPAN) begin
                v = SPAN;
            end
            return aalr_pkg::PIX_W'(v);
        endfunction

        function automatic void push_pixel(longint major, longint minor, longint opac,
                                           bit last, bit done);
            pixel_t p;
            p.x        = on_screen(steep ? minor : major);
            p.y        = on_screen(steep ? major : minor);
            p.coverage = gamma_cov(opac);
            p.color    = color;
            p.last     = last;
            p.done     = done;
            expected_pixels.push_back(p);
        endfunction

        // Floor and the two fractional weights of a fixed-point minor coordinate
        function automatic void split_minor(longint v, output longint ip, output longint fp,
                                            output longint rf);
            ip = v >>> GRAD_FRAC;
            fp = v - (ip <<< GRAD_FRAC);
            rf = (longint'(1) <<< GRAD_FRAC) - fp;
        endfunction

        function automatic void endpoint_pair(longint xq, longint yq, bit first, bit done,
                                              output longint xe, output longint y);
            longint d, frac, gap, ip, fp, rf;
            xe   = (xq + 8) >>> 4;
            d    = xe * 16 - xq;
            y    = (yq <<< (GRAD_FRAC - 4)) + ((gradient * d) >>> 4);
            frac = (xq + 8) & 15;
            gap  = first ? 16 - frac : frac;
            split_minor(y, ip, fp, rf);
            push_pixel(xe, ip, (rf * gap) >>> (GRAD_FRAC - 4), 1'b0, done);
            push_pixel(xe, ip + 1, (fp * gap) >>> (GRAD_FRAC - 4), !first, done);
        endfunction

        // Update the line state for one accepted item; return how many pixels it yields
        function automatic int predict_pixels(logic kind,
                                              logic [aalr_pkg::COORD_W-1:0] sx,
                                              logic [aalr_pkg::COORD_W-1:0] sy,
                                              logic [aalr_pkg::COORD_W-1:0] ex,
                                              logic [aalr_pkg::COORD_W-1:0] ey,
                                              logic [aalr_pkg::COLOR_W-1:0] c);
            longint x0, y0, x1, y1, t, dx, dy, adx, ady, mag, xe1, xe2, ye1, ye2;
            longint ip, fp, rf;
            bit done;
            if (kind == aalr_pkg::KIND_LOAD) begin
                x0 = sx;
                y0 = sy;
                x1 = ex;
                y1 = ey;
                color = c;
                adx = (x1 > x0) ? x1 - x0 : x0 - x1;
                ady = (y1 > y0) ? y1 - y0 : y0 - y1;
                steep = ady > adx;
                if (steep) begin
                    t = x0; x0 = y0; y0 = t;
                    t = x1; x1 = y1; y1 = t;
                end
                if (x0 > x1) begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                dx = x1 - x0;
                dy = y1 - y0;
                if (dx == 0) begin
                    gradient = 0;
                end else begin
                    mag = ((dy < 0 ? -dy : dy) <<< GRAD_FRAC) / dx;
                    gradient = (dy < 0) ? -mag : mag;
                end
                done = ((x0 + 8) >>> 4) + 1 >= ((x1 + 8) >>> 4);
                endpoint_pair(x0, y0, 1'b1, done, xe1, ye1);
                endpoint_pair(x1, y1, 1'b0, done, xe2, ye2);
                minor_acc   = ye1 + gradient;
                next_col    = xe1 + 1;
                end_col     = xe2;
                line_active = next_col < end_col;
                return 4;
            end
            if (!line_active) begin
                return 0;
            end
            done = next_col + 1 >= end_col;
            split_minor(minor_acc, ip, fp, rf);
            push_pixel(next_col, ip, rf >>> (GRAD_FRAC - 8), 1'b0, done);
            push_pixel(next_col, ip + 1, fp >>> (GRAD_FRAC - 8), 1'b1, done);
            next_col++;
            minor_acc += gradient;
            if (done) begin
                line_active = 1'b0;
            end
            return 2;
        endfunction

        function automatic void report(string field, logic [31:0] want, logic [31:0] got);
            failures++;
            $error("%s: expected %0d, got %0d", field, want, got);
        endfunction

        function automatic void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                failures++;
                $error("unexpected pixel at (%0d, %0d)", got.x, got.y);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.x !== want.x) report("pixel_x", want.x, got.x);
            if (got.y !== want.y) report("pixel_y", want.y, got.y);
            if (got.coverage !== want.coverage) report("coverage", want.coverage, got.coverage);
            if (got.color !== want.color) report("pixel_color", want.color, got.color);
            if (got.last !== want.last) report("last", want.last, got.last);
            if (got.done !== want.done) report("line_done", want.done, got.done);
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_kind = aalr_pkg::KIND_LOAD;
    logic [aalr_pkg::COORD_W-1:0] s_start_x = '0;
    logic [aalr_pkg::COORD_W-1:0] s_start_y = '0;
    logic [aalr_pkg::COORD_W-1:0] s_end_x = '0;
    logic [aalr_pkg::COORD_W-1:0] s_end_y = '0;
    logic [aalr_pkg::COLOR_W-1:0] s_line_color = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [aalr_pkg::PIX_W-1:0]   m_pixel_x;
    logic [aalr_pkg::PIX_W-1:0]   m_pixel_y;
    logic [aalr_pkg::COV_W-1:0]   m_coverage;
    logic [aalr_pkg::COLOR_W-1:0] m_pixel_color;
    logic                         m_last;
    logic                         m_line_done;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;

    pixel_scoreboard sb = new();

    antialiased_line_rasterizer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_line_color  (s_line_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_coverage    (m_coverage),
        .m_pixel_color (m_pixel_color),
        .m_last        (m_last),
        .m_line_done   (m_line_done)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            sb.check_pixel({m_pixel_x, m_pixel_y, m_coverage, m_pixel_color, m_last,
                            m_line_done});
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("antialiased_line_rasterizer regression: fail");
            $finish;
        end
    end

    // Present one item, hold it until the transfer, then note it for prediction
    task automatic send_item(input logic kind, input int sx, input int sy, input int ex,
                             input int ey, input logic [aalr_pkg::COLOR_W-1:0] c,
                             output int produced);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_start_x    <= aalr_pkg::COORD_W'(sx);
        s_start_y    <= aalr_pkg::COORD_W'(sy);
        s_end_x      <= aalr_pkg::COORD_W'(ex);
        s_end_y      <= aalr_pkg::COORD_W'(ey);
        s_line_color <= c;
        do @(posedge aclk); while (s_ready !== 1'b1);
        produced = sb.predict_pixels(kind, aalr_pkg::COORD_W'(sx), aalr_pkg::COORD_W'(sy),
                                     aalr_pkg::COORD_W'(ex), aalr_pkg::COORD_W'(ey), c);
    endtask

    // Advance payloads are ignored by the block; fill them with noise
    task automatic advance(output int produced);
        send_item(aalr_pkg::KIND_ADVANCE, $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), aalr_pkg::COLOR_W'($urandom), produced);
    endtask

    function automatic int near_coord(int base, int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    initial begin
        int produced, counted, phase, span, steps, k;
        int sx, sy, ex, ey;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 38;
        recv_idle_pct = 69;

        // advance with no line loaded: must yield nothing
        advance(produced);
        // zero-length line at the origin and at the far corner (off screen)
        send_item(aalr_pkg::KIND_LOAD, 0, 0, 0, 0, 24'h000000, produced);
        send_item(aalr_pkg::KIND_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  24'hFFFFFF, produced);
        // full-screen diagonal, endpoints given right to left
        send_item(aalr_pkg::KIND_LOAD, COORD_MAX, 0, 0, COORD_MAX, 24'hA5A5A5, produced);
        repeat (2) advance(produced);
        // first endpoint falls just above row 0, so its upper pixel is off screen
        send_item(aalr_pkg::KIND_LOAD, 1, 0, 1600, 800, 24'h5A5A5A, produced);
        repeat (2) advance(produced);
        // steep lines, the second given with its endpoints in reverse order
        send_item(aalr_pkg::KIND_LOAD, 100, 0, 300, 3000, 24'h123456, produced);
        repeat (3) advance(produced);
        send_item(aalr_pkg::KIND_LOAD, 5000, 9000, 4800, 2000, 24'hFEDCBA, produced);
        repeat (2) advance(produced);
        // endpoints in adjacent columns: no interior, the advance is dropped
        send_item(aalr_pkg::KIND_LOAD, 16, 16, 30, 20, 24'h00FF00, produced);
        advance(produced);
        // short line run to its end plus one extra advance
        send_item(aalr_pkg::KIND_LOAD, 40, 40, 100, 60, 24'hFF00FF, produced);
        repeat (3) advance(produced);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            counted = 0;
            while (counted < 69) begin
                span = ($urandom_range(0, 9) == 0) ? COORD_MAX : 320;
                sx = $urandom_range(0, COORD_MAX);
                sy = $urandom_range(0, COORD_MAX);
                ex = near_coord(sx, span);
                ey = ($urandom_range(0, 9) == 0) ? sy : near_coord(sy, span);
                send_item(aalr_pkg::KIND_LOAD, sx, sy, ex, ey, aalr_pkg::COLOR_W'($urandom),
                          produced);
                counted++;
                // mostly walk the line to its end; sometimes cut it short with a new load
                steps = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 3) : 24;
                k = 0;
                while (sb.line_active && k < steps) begin
                    advance(produced);
                    k++;
                    counted++;
                end
                if ($urandom_range(0, 99) < 30) begin
                    advance(produced);
                    if (produced > 0) counted++;
                end
            end
        end
        s_valid <= 1'b0;

        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("antialiased_line_rasterizer regression: pass");
        end else begin
            $display("antialiased_line_rasterizer regression: fail");
        end
        $finish;
    end

endmodule
